FILE: rtl/mf5_pkg.sv
// Shared constants and types for the five-tap median filter.
package mf5_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int TAPS = 5;
   localparam int HISTORY = TAPS - 1;
   localparam int MEDIAN_RANK = TAPS / 2;
   localparam int RAW_HEAD = 2;
   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
   localparam int LEVEL_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int PUSH_BITS = $clog2(MAX_RESULTS + 1);
   localparam int RANK_BITS = $clog2(TAPS);
   localparam int COUNT_BITS = $clog2(HISTORY + 1);

   localparam logic [LEVEL_BITS-1:0] ROOM_LIMIT = LEVEL_BITS'(QUEUE_DEPTH - MAX_RESULTS);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   // Bit d-1 is set when the sample d places older is less than or equal to this one.
   typedef logic [HISTORY-2:0] order_type;

   typedef struct packed {
      sample_type value;
      logic last_out;
   } rsp_item_type;

   typedef struct packed {
      logic [PUSH_BITS-1:0] count;
      rsp_item_type [MAX_RESULTS-1:0] items;
   } push_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] level;
      logic room;
   } queue_status_type;

endpackage

FILE: rtl/mf5_if.sv
// Stream interfaces for the sample channel and the result channel.
interface mf5_req_if;
   logic valid;
   logic ready;
   logic signed [mf5_pkg::SAMPLE_BITS-1:0] sample;
   logic last;

   modport source (output valid, output sample, output last, input ready);
   modport sink (input valid, input sample, input last, output ready);
endinterface

interface mf5_rsp_if;
   logic valid;
   logic ready;
   logic signed [mf5_pkg::SAMPLE_BITS-1:0] value;
   logic last_out;

   modport source (output valid, output value, output last_out, input ready);
   modport sink (input valid, input value, input last_out, output ready);
endinterface

FILE: rtl/median_filter_5tap.sv
// Top level of the five-tap sliding-window median filter.
//
//   channel   direction   transaction carries
//   req_ch    in          sample, last
//   rsp_ch    out         value, last_out
//
// One sample is taken per cycle while the queue has room; results are queued the next cycle.
// The median is found in the same cycle from orders kept in the window cells.
// A record end adds up to three results, and the queue may then hold off req_ch
// while they drain. Stalls on rsp_ch back up into req_ch only once the four-entry
// result queue cannot take three more results.
// Reset clears the sample count and the queue; window samples need no reset.
module median_filter_5tap (
   input logic     clock,
   input logic     reset,
   mf5_req_if.sink req_ch,
   mf5_rsp_if.source rsp_ch
);

   localparam int H = mf5_pkg::HISTORY;

   mf5_pkg::sample_type x;
   logic accept;
   mf5_pkg::queue_status_type status;
   mf5_pkg::push_type push;
   logic [mf5_pkg::COUNT_BITS-1:0] seen_ff, seen_in;

   mf5_pkg::sample_type cell_value [H];
   mf5_pkg::order_type cell_order [H];
   logic [H-1:0] cell_le;
   mf5_pkg::order_type new_order;

   mf5_pkg::sample_type elem [mf5_pkg::TAPS];
   logic [mf5_pkg::TAPS-1:0] prec [mf5_pkg::TAPS];
   logic [mf5_pkg::RANK_BITS-1:0] rank [mf5_pkg::TAPS];
   logic [mf5_pkg::TAPS-1:0] rank_hit;
   mf5_pkg::sample_type median;

   assign x = req_ch.sample;
   assign req_ch.ready = status.room;
   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      for (int d = 1; d < H; d++) begin
         new_order[d-1] = cell_le[H-d];
      end
   end

   for (genvar j = 0; j < H; j++) begin : g_cell
      if (j == H - 1) begin : g_newest
         mf5_cell u_cell (
            .clock       (clock),
            .shift_en    (accept),
            .shift_value (x),
            .shift_order (new_order),
            .newest      (x),
            .value       (cell_value[j]),
            .order       (cell_order[j]),
            .le_newest   (cell_le[j])
         );
      end else begin : g_inner
         mf5_cell u_cell (
            .clock       (clock),
            .shift_en    (accept),
            .shift_value (cell_value[j+1]),
            .shift_order (cell_order[j+1]),
            .newest      (x),
            .value       (cell_value[j]),
            .order       (cell_order[j]),
            .le_newest   (cell_le[j])
         );
      end
   end

   always_comb begin
      for (int e = 0; e < H; e++) begin
         elem[e] = cell_value[e];
      end
      elem[H] = x;
      for (int e = 0; e < mf5_pkg::TAPS; e++) begin
         prec[e] = '0;
      end
      for (int j = 1; j < H; j++) begin
         for (int i = 0; i < j; i++) begin
            prec[i][j] = cell_order[j][j-i-1];
         end
      end
      for (int i = 0; i < H; i++) begin
         prec[i][H] = cell_le[i];
      end
   end

   always_comb begin
      median = '0;
      for (int e = 0; e < mf5_pkg::TAPS; e++) begin
         rank[e] = '0;
         for (int o = 0; o < mf5_pkg::TAPS; o++) begin
            if (o < e) begin
               rank[e] = rank[e] + mf5_pkg::RANK_BITS'(prec[o][e]);
            end else if (o > e) begin
               rank[e] = rank[e] + mf5_pkg::RANK_BITS'(!prec[e][o]);
            end
         end
         rank_hit[e] = (rank[e] == mf5_pkg::RANK_BITS'(mf5_pkg::MEDIAN_RANK));
         median = median | (elem[e] & {mf5_pkg::SAMPLE_BITS{rank_hit[e]}});
      end
   end

   always_comb begin
      int k;
      k = 0;
      push.items = '0;
      if (seen_ff < mf5_pkg::COUNT_BITS'(mf5_pkg::RAW_HEAD)) begin
         push.items[k] = '{value: x, last_out: req_ch.last};
         k = k + 1;
      end else begin
         if (seen_ff == mf5_pkg::COUNT_BITS'(H)) begin
            push.items[k] = '{value: median, last_out: 1'b0};
            k = k + 1;
         end
         if (req_ch.last) begin
            if (seen_ff >= mf5_pkg::COUNT_BITS'(H - 1)) begin
               push.items[k] = '{value: cell_value[H-1], last_out: 1'b0};
               k = k + 1;
            end
            push.items[k] = '{value: x, last_out: 1'b1};
            k = k + 1;
         end
      end
      push.count = accept ? mf5_pkg::PUSH_BITS'(k) : '0;
   end

   always_comb begin
      seen_in = seen_ff;
      if (accept) begin
         if (req_ch.last) begin
            seen_in = '0;
         end else if (seen_ff < mf5_pkg::COUNT_BITS'(H)) begin
            seen_in = seen_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   mf5_out_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .status (status),
      .rsp_ch (rsp_ch)
   );

   // The window order must single out exactly one median sample.
   a_median_unique: assert property (@(posedge clock) disable iff (reset)
      (accept && seen_ff == mf5_pkg::COUNT_BITS'(H)) |-> $onehot(rank_hit))
      else $error("median selection is not unique");

   a_record_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.last) |=> (seen_ff == '0))
      else $error("sample count did not restart after record end");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      status.level <= mf5_pkg::LEVEL_BITS'(mf5_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");

   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= mf5_pkg::COUNT_BITS'(H))
      else $error("sample count beyond saturation");

endmodule

FILE: rtl/mf5_cell.sv
// One window cell: holds a sample and its order against older samples.
module mf5_cell (
   input  logic                clock,
   input  logic                shift_en,
   input  mf5_pkg::sample_type shift_value,
   input  mf5_pkg::order_type  shift_order,
   input  mf5_pkg::sample_type newest,
   output mf5_pkg::sample_type value,
   output mf5_pkg::order_type  order,
   output logic                le_newest
);

   mf5_pkg::sample_type value_ff, value_in;
   mf5_pkg::order_type order_ff, order_in;

   always_comb begin
      value_in = shift_en ? shift_value : value_ff;
      order_in = shift_en ? shift_order : order_ff;
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      order_ff <= order_in;
   end

   assign value = value_ff;
   assign order = order_ff;
   assign le_newest = (value_ff <= newest);

endmodule

FILE: rtl/mf5_out_queue.sv
// Result queue that takes up to three results per cycle and hands out one while rsp_ch is ready.
module mf5_out_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  mf5_pkg::push_type         push,
   output mf5_pkg::queue_status_type status,
   mf5_rsp_if.source                 rsp_ch
);

   mf5_pkg::rsp_item_type mem_ff [mf5_pkg::QUEUE_DEPTH];
   logic [mf5_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mf5_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mf5_pkg::LEVEL_BITS-1:0] level_ff, level_in;
   logic pop;

   assign rsp_ch.valid = (level_ff != '0);
   assign rsp_ch.value = mem_ff[rd_ptr_ff].value;
   assign rsp_ch.last_out = mem_ff[rd_ptr_ff].last_out;
   assign pop = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + mf5_pkg::QUEUE_AW'(push.count);
      rd_ptr_in = rd_ptr_ff + mf5_pkg::QUEUE_AW'(pop);
      level_in = level_ff + mf5_pkg::LEVEL_BITS'(push.count) - mf5_pkg::LEVEL_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < mf5_pkg::MAX_RESULTS; k++) begin
         if (k < int'(push.count)) begin
            mem_ff[wr_ptr_ff + mf5_pkg::QUEUE_AW'(k)] <= push.items[k];
         end
      end
   end

   assign status.level = level_ff;
   assign status.room = (level_ff <= mf5_pkg::ROOM_LIMIT);

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the five-tap median filter with random handshakes.
`timescale 1ns / 1ps

module tb;

   typedef struct packed {
      mf5_pkg::sample_type sample;
      logic last;
   } req_item_type;

   localparam int ITEM_TARGET = 480;
   localparam int DIRECTED_COUNT = 22;
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AFTER = 150;

   localparam mf5_pkg::sample_type DIRECTED_SAMPLES [DIRECTED_COUNT] = '{
      32767,
      -32768, 0,
      -1, 32767, -32768,
      1, -2, 16384, -16385,
      5, 5, 5, 5, 5,
      32767, -32768, 32767, -32768, 0, -1, 32767
   };
   localparam bit DIRECTED_LAST [DIRECTED_COUNT] = '{
      1,
      0, 1,
      0, 0, 1,
      0, 0, 0, 1,
      0, 0, 0, 0, 1,
      0, 0, 0, 0, 0, 0, 1
   };

   logic clock;
   logic reset;

   mf5_req_if req_if ();
   mf5_rsp_if rsp_if ();

   median_filter_5tap dut (
      .clock (clock),
      .reset (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   req_item_type pending_q[$];
   mf5_pkg::rsp_item_type filtered_q[$];

   mf5_pkg::sample_type history[mf5_pkg::HISTORY];
   int record_fill;

   int stimulus_total;
   int sent_total;
   int checked_total;
   int mismatch_count;
   int send_gap;
   int rsp_stall;
   int hold_left;
   logic hold_done;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   // Mirrors the filter state and queues the results one input sample produces.
   task automatic predict_filter(input mf5_pkg::sample_type x, input logic fin);
      mf5_pkg::sample_type taps[mf5_pkg::TAPS];
      mf5_pkg::sample_type t;
      int n;
      n = record_fill;
      if (n < mf5_pkg::RAW_HEAD) begin
         filtered_q.push_back('{value: x, last_out: fin});
      end else begin
         if (n >= mf5_pkg::HISTORY) begin
            for (int i = 0; i < mf5_pkg::HISTORY; i++) taps[i] = history[i];
            taps[mf5_pkg::HISTORY] = x;
            for (int i = 0; i < mf5_pkg::TAPS - 1; i++) begin
               for (int j = 0; j < mf5_pkg::TAPS - 1 - i; j++) begin
                  if (taps[j] > taps[j + 1]) begin
                     t = taps[j];
                     taps[j] = taps[j + 1];
                     taps[j + 1] = t;
                  end
               end
            end
            filtered_q.push_back('{value: taps[mf5_pkg::MEDIAN_RANK], last_out: 1'b0});
         end
         if (fin) begin
            if (n >= 3) begin
               filtered_q.push_back('{value: history[mf5_pkg::HISTORY - 1], last_out: 1'b0});
            end
            filtered_q.push_back('{value: x, last_out: 1'b1});
         end
      end
      for (int i = 0; i < mf5_pkg::HISTORY - 1; i++) history[i] = history[i + 1];
      history[mf5_pkg::HISTORY - 1] = x;
      if (fin) record_fill = 0;
      else if (n < mf5_pkg::HISTORY) record_fill = n + 1;
   endtask

   initial begin
      int rec_len;
      int pick;
      int style;
      mf5_pkg::sample_type s;
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.sample = '0;
      req_if.last = 1'b0;
      rsp_if.ready = 1'b0;
      record_fill = 0;
      mismatch_count = 0;
      for (int i = 0; i < mf5_pkg::HISTORY; i++) history[i] = '0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         pending_q.push_back('{sample: DIRECTED_SAMPLES[i], last: DIRECTED_LAST[i]});
      end
      // Short records, typical records and a few long ones, with values drawn from the
      // full range, from a narrow band that forces ties, or from the extremes.
      while (pending_q.size() < ITEM_TARGET) begin
         pick = $urandom_range(0, 9);
         if (pick < 3) rec_len = $urandom_range(1, 4);
         else if (pick < 9) rec_len = $urandom_range(5, 20);
         else rec_len = $urandom_range(21, 50);
         style = $urandom_range(0, 2);
         for (int i = 0; i < rec_len; i++) begin
            if (style == 1) begin
               s = mf5_pkg::sample_type'(int'($urandom_range(0, 6)) - 3);
            end else if (style == 2 && $urandom_range(0, 1) == 0) begin
               case ($urandom_range(0, 3))
                  0: s = 16'sh7fff;
                  1: s = 16'sh8000;
                  2: s = 16'sh0000;
                  default: s = 16'shffff;
               endcase
            end else begin
               s = mf5_pkg::sample_type'($urandom);
            end
            pending_q.push_back('{sample: s, last: (i == rec_len - 1)});
         end
      end
      stimulus_total = pending_q.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (sent_total != stimulus_total || filtered_q.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && filtered_q.size() == 0) begin
         $display("PASS median_filter_5tap");
      end else begin
         $display("FAIL median_filter_5tap");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL median_filter_5tap");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.sample <= '0;
         req_if.last <= 1'b0;
         send_gap = 0;
         sent_total <= 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid) begin
            predict_filter(req_if.sample, req_if.last);
            sent_total <= sent_total + 1;
            send_gap = ((sent_total % 96) < 24) ? 0 : $urandom_range(0, 12);
         end
         if (send_gap == 0 && pending_q.size() > 0) begin
            req_if.valid <= 1'b1;
            req_if.sample <= pending_q[0].sample;
            req_if.last <= pending_q[0].last;
            void'(pending_q.pop_front());
         end else begin
            req_if.valid <= 1'b0;
            if (send_gap > 0) send_gap--;
         end
      end
   end

   always @(posedge clock) begin
      mf5_pkg::rsp_item_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall = 0;
         checked_total <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (filtered_q.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction value %0d last_out %0b",
                                         rsp_if.value, rsp_if.last_out));
            end else begin
               want = filtered_q.pop_front();
               if (rsp_if.value !== want.value)
                  report_mismatch($sformatf("value %0d, expected %0d",
                                            rsp_if.value, want.value));
               if (rsp_if.last_out !== want.last_out)
                  report_mismatch($sformatf("last_out %0b, expected %0b",
                                            rsp_if.last_out, want.last_out));
            end
            checked_total <= checked_total + 1;
            rsp_stall = ((checked_total % 80) < 20) ? 0 : $urandom_range(0, 12);
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_if.ready <= (rsp_stall == 0) && (hold_left == 0);
      end
   end

   // One long receiver stall partway through, so the result queue fills and req_ch backs up.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && checked_total >= HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

endmodule

FILE: median_filter_5tap.f
rtl/mf5_pkg.sv
rtl/mf5_if.sv
rtl/mf5_cell.sv
rtl/mf5_out_queue.sv
rtl/median_filter_5tap.sv
bench/tb.sv
